// ===== design/mtr_pkg.sv =====
package mtr_pkg;

    localparam int TILE_PIXELS = 256;
    localparam int TILE_SHIFT  = $clog2(TILE_PIXELS);
    localparam int MAX_TILES   = 8;
    localparam int MERC_DEPTH  = 1024;
    localparam int MERC_IDX_W  = $clog2(MERC_DEPTH + 1);
    localparam int MAX_ZOOM    = 20;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] PHI_MAX_Q30 = 64'd1593886233;

    localparam logic [29:0]        LAT_LIMIT = 30'd850511288;
    localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
    localparam logic [31:0]        LON_SPAN  = 32'd3600000000;

    // fx is u * 2^32 over 3600000000, which equals u * 2^23 over 7031250
    localparam logic [22:0] LON_DIV   = 23'd7031250;
    localparam logic [32:0] LON_RECIP = 33'((64'd1 << 55) / 64'd7031250);
    // p is a * 1024 * 2^16 over LAT_LIMIT, which equals a * 2^23 over 106313911
    localparam logic [26:0] LAT_DIV   = 27'd106313911;
    localparam logic [26:0] LAT_RECIP = 27'((64'd1 << 53) / 64'd106313911);

    localparam logic [1:0] REG_ZOOM   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [19:0] lo;
        logic [19:0] hi;
    } span_t;

    typedef logic [30:0] merc_rom_t [MERC_DEPTH + 1];

    // elaboration-time quotient, shift and subtract
    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int          b;
        rem = '0;
        q   = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= 65'(d))
            begin
                rem  = rem - 65'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        int          k;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 12; k++)
        begin
            term = cdiv((term * x2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
            if ((k & 1) != 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return 64'(acc);
    endfunction

    function automatic logic [63:0] atanh_q30(input logic [63:0] s_in);
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        int          i;
        int          j;
        s   = s_in;
        sum = 64'd0;
        k   = 64'd0;
        if (s > Q30_ONE - 64'd1)
            s = Q30_ONE - 64'd1;
        r = cdiv((Q30_ONE + s) << 30, Q30_ONE - s);
        for (i = 0; i < 64; i++)
        begin
            if (r >= 64'd2 * Q30_ONE)
            begin
                r = r >> 1;
                k = k + 64'd1;
            end
        end
        z  = cdiv((r - Q30_ONE) << 30, r + Q30_ONE);
        z2 = (z * z) >> 30;
        p  = z;
        for (j = 0; j < 12; j++)
        begin
            sum = sum + cdiv(p, 64'(2 * j + 1));
            p   = (p * z2) >> 30;
        end
        return sum + ((k * LN2_Q30) >> 1);
    endfunction

    function automatic merc_rom_t build_merc_rom();
        merc_rom_t   rom;
        logic [63:0] phi;
        logic [63:0] m;
        int          i;
        for (i = 0; i < MERC_DEPTH; i++)
        begin
            phi = cdiv(PHI_MAX_Q30 * 64'(i), 64'(MERC_DEPTH));
            m   = cdiv(atanh_q30(sin_q30(phi)) * Q30_ONE, PI_Q30);
            if (m > Q30_ONE)
                m = Q30_ONE;
            rom[i] = 31'(m);
        end
        rom[MERC_DEPTH] = 31'(Q30_ONE);
        return rom;
    endfunction

    localparam merc_rom_t MERC_ROM = build_merc_rom();

endpackage

// ===== design/map_tile_range_for_view_unit.sv =====
// Map tile range for a view around one GPS position.
// Request channel: req_valid and req_stall with latitude and longitude in
// 1e-7 degree units. A request is taken at a clock edge with req_valid high
// and req_stall low.
// Tile channel: tile_valid and tile_stall with tile_x, tile_y and last_tile.
// Tiles of one request come x outer, y inner; last_tile marks the final one.
// Config: cfg_write, cfg_index (0 zoom, 1 view width, 2 view height) and
// cfg_data; write only while no request is in flight.
// Pipeline: a taken request passes nine pipeline stages (Mercator ROM read in
// stage five), then the tile counter puts its first tile on the ports once
// the tile stage is free.
// Throughput: one tile per cycle while tile_stall is low; a request yields
// (x tiles) * (y tiles) tiles, at most 64. Up to nine further requests queue
// in the pipeline behind it; the whole pipeline holds while the counter is
// busy, except in the cycle its last tile is taken.
// Reset: clears all valid bits and loads zoom 15, view 1024 x 768.
// A stall on the tile channel holds the current tile on the ports; req_stall
// stays high while the counter is busy and its last tile is not taken.
module map_tile_range_for_view_unit
    import mtr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    output logic               tile_valid,
    input  logic               tile_stall,
    output logic [19:0]        tile_x,
    output logic [19:0]        tile_y,
    output logic               last_tile
);

    logic [4:0]  zoom_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    logic [4:0]  zoom;
    logic [19:0] max_index;

    logic adv;
    logic take;
    logic at_last;

    logic [9:1] v_reg;

    // stage 1
    logic signed [30:0] lat1_reg;
    logic signed [31:0] lon1_reg;
    // stage 2
    logic [31:0] u2_reg, u2_next;
    logic [29:0] a2_reg, a2_next;
    logic        south2_reg;
    logic [30:0] amag;
    logic signed [32:0] lon_sum;
    // stage 3
    logic [32:0] qx3_reg, qx3_next;
    logic [26:0] qy3_reg, qy3_next;
    logic [31:0] u3_reg;
    logic [29:0] a3_reg;
    logic        south3_reg;
    logic [64:0] prod_x;
    logic [56:0] prod_y;
    // stage 4
    logic [32:0] fx4_reg, fx4_next;
    logic [26:0] p4_reg, p4_next;
    logic        south4_reg;
    logic [55:0] rem_x;
    logic [53:0] rem_y;
    // stage 5
    logic [MERC_IDX_W-1:0] idx0, idx1;
    logic [30:0] t0_5_reg, t1_5_reg;
    logic [15:0] wgt5_reg;
    logic        south5_reg;
    logic [28:0] wx5_reg, wx5_next;
    logic [52:0] fx_shift;
    // stage 6
    logic [30:0] prod6_reg, prod6_next;
    logic [30:0] t0_6_reg;
    logic        south6_reg;
    span_t       xs6_reg, xs6_next;
    logic [30:0] dlt;
    logic [46:0] dprod;
    // stage 7
    logic [32:0] fy7_reg, fy7_next;
    span_t       xs7_reg;
    logic [31:0] msum;
    logic [31:0] mcap;
    // stage 8
    logic [28:0] wy8_reg, wy8_next;
    span_t       xs8_reg;
    logic [52:0] fy_shift;
    // stage 9
    span_t       ys9_reg, ys9_next;
    span_t       xs9_reg;
    // tile counter
    logic        busy_reg;
    logic [19:0] cx_reg, cy_reg, ylo_reg, xhi_reg, yhi_reg;

    function automatic span_t tile_span(input logic [28:0] w, input logic [9:0] half,
                                        input logic [19:0] maxi);
        logic [28:0] dlo;
        logic [20:0] tlo;
        logic [19:0] lo;
        logic [29:0] shi;
        logic [21:0] hi0;
        logic [21:0] cap;
        logic [21:0] lim;
        span_t       r;
        dlo = w - 29'(half);
        tlo = 21'(dlo >> TILE_SHIFT);
        if (w < 29'(half) || tlo == 21'd0)
            lo = 20'd0;
        else
            lo = 20'(tlo - 21'd1);
        shi = 30'(w) + 30'(half);
        hi0 = 22'(shi >> TILE_SHIFT) + 22'd1;
        cap = (hi0 > 22'(maxi)) ? 22'(maxi) : hi0;
        lim = 22'(lo) + 22'(MAX_TILES - 1);
        if (cap > lim)
            cap = lim;
        r.lo = lo;
        r.hi = cap[19:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg   <= 5'd15;
            width_reg  <= 11'd1024;
            height_reg <= 11'd768;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ZOOM:   zoom_reg   <= cfg_data[4:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign zoom      = (zoom_reg > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom_reg;
    assign max_index = 20'((21'd1 << zoom) - 21'd1);

    assign at_last   = (cx_reg == xhi_reg) && (cy_reg == yhi_reg);
    assign take      = busy_reg && !tile_stall;
    assign adv       = !busy_reg || (take && at_last);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[8:1], req_valid};
    end

    // stage 2: saturation
    assign lon_sum = 33'(lon1_reg) + 33'(LON_LIMIT);
    assign amag    = lat1_reg[30] ? 31'(-lat1_reg) : 31'(lat1_reg);
    assign a2_next = (amag > 31'(LAT_LIMIT)) ? LAT_LIMIT : amag[29:0];
    assign u2_next = (lon1_reg > LON_LIMIT)  ? LON_SPAN :
                     (lon1_reg < -LON_LIMIT) ? 32'd0 : lon_sum[31:0];

    // stage 3: reciprocal estimates
    assign prod_x   = 65'(u2_reg) * 65'(LON_RECIP);
    assign prod_y   = 57'(a2_reg) * 57'(LAT_RECIP);
    assign qx3_next = prod_x[64:32];
    assign qy3_next = prod_y[56:30];

    // stage 4: one-step correction
    assign rem_x   = {1'b0, u3_reg, 23'd0} - (56'(qx3_reg) * 56'(LON_DIV));
    assign rem_y   = {1'b0, a3_reg, 23'd0} - (54'(qy3_reg) * 54'(LAT_DIV));
    assign fx4_next = qx3_reg + 33'(rem_x >= 56'(LON_DIV));
    assign p4_next  = qy3_reg + 27'(rem_y >= 54'(LAT_DIV));

    // stage 5: ROM read, x pixel
    assign idx0     = p4_reg[26:16];
    assign idx1     = (idx0 == MERC_IDX_W'(MERC_DEPTH)) ? idx0 : idx0 + MERC_IDX_W'(1);
    assign fx_shift = 53'(fx4_reg) << zoom;
    assign wx5_next = fx_shift[52:24];

    // stage 6: interpolation product, x span
    assign dlt        = (t1_5_reg > t0_5_reg) ? t1_5_reg - t0_5_reg : 31'd0;
    assign dprod      = 47'(dlt) * 47'(wgt5_reg);
    assign prod6_next = dprod[46:16];
    assign xs6_next   = tile_span(wx5_reg, width_reg[10:1], max_index);

    // stage 7: y fraction
    assign msum     = 32'(t0_6_reg) + 32'(prod6_reg);
    assign mcap     = (msum > 32'(Q30_ONE)) ? 32'(Q30_ONE) : msum;
    assign fy7_next = south6_reg ? 33'((33'(Q30_ONE) + 33'(mcap)) << 1)
                                 : 33'((33'(Q30_ONE) - 33'(mcap)) << 1);

    // stage 8: y pixel
    assign fy_shift = 53'(fy7_reg) << zoom;
    assign wy8_next = fy_shift[52:24];

    // stage 9: y span
    assign ys9_next = tile_span(wy8_reg, height_reg[10:1], max_index);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat1_reg   <= latitude;
            lon1_reg   <= longitude;

            u2_reg     <= u2_next;
            a2_reg     <= a2_next;
            south2_reg <= lat1_reg[30];

            qx3_reg    <= qx3_next;
            qy3_reg    <= qy3_next;
            u3_reg     <= u2_reg;
            a3_reg     <= a2_reg;
            south3_reg <= south2_reg;

            fx4_reg    <= fx4_next;
            p4_reg     <= p4_next;
            south4_reg <= south3_reg;

            t0_5_reg   <= MERC_ROM[idx0];
            t1_5_reg   <= MERC_ROM[idx1];
            wgt5_reg   <= p4_reg[15:0];
            south5_reg <= south4_reg;
            wx5_reg    <= wx5_next;

            prod6_reg  <= prod6_next;
            t0_6_reg   <= t0_5_reg;
            south6_reg <= south5_reg;
            xs6_reg    <= xs6_next;

            fy7_reg    <= fy7_next;
            xs7_reg    <= xs6_reg;

            wy8_reg    <= wy8_next;
            xs8_reg    <= xs7_reg;

            ys9_reg    <= ys9_next;
            xs9_reg    <= xs8_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (adv)
            busy_reg <= v_reg[9];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= xs9_reg.lo;
            cy_reg  <= ys9_reg.lo;
            ylo_reg <= ys9_reg.lo;
            xhi_reg <= xs9_reg.hi;
            yhi_reg <= ys9_reg.hi;
        end
        else if (take)
        begin
            if (cy_reg == yhi_reg)
            begin
                cx_reg <= cx_reg + 20'd1;
                cy_reg <= ylo_reg;
            end
            else
            begin
                cy_reg <= cy_reg + 20'd1;
            end
        end
    end

    assign tile_valid = busy_reg;
    assign tile_x     = cx_reg;
    assign tile_y     = cy_reg;
    assign last_tile  = at_last;

endmodule

// ===== design/mtr_checker.sv =====
module mtr_checker
    import mtr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_stall,
    input logic               tile_valid,
    input logic               tile_stall,
    input logic [19:0]        tile_x,
    input logic [19:0]        tile_y,
    input logic               last_tile
);

    // stalled tile holds
    assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && tile_stall |=> tile_valid && $stable(tile_x) && $stable(tile_y)
                                     && $stable(last_tile))
    else $error("stalled tile changed");

    // a request's tile run has no gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && !tile_stall && !last_tile |=> tile_valid)
    else $error("tile run broken before last tile");

    // within a run, x stays or steps by one
    assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && !tile_stall && !last_tile |=>
            (tile_x == $past(tile_x)) || (tile_x == $past(tile_x) + 20'd1))
    else $error("tile_x jumped within a run");

    // idle tile stage never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !tile_valid |-> !req_stall)
    else $error("request stalled while tile stage idle");

endmodule

bind map_tile_range_for_view_unit mtr_checker u_mtr_checker (.*);

// ===== verif/map_tile_range_for_view_unit_tb.sv =====
`timescale 1ns / 1ps

module map_tile_range_for_view_unit_tb;
    import mtr_pkg::*;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
    } gps_req_t;

    typedef struct packed {
        logic [19:0] x;
        logic [19:0] y;
        logic        last;
    } tile_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = REG_ZOOM;
    logic [10:0]        cfg_data = '0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic signed [30:0] latitude = '0;
    logic signed [31:0] longitude = '0;
    logic               tile_valid;
    logic               tile_stall = 1'b0;
    logic [19:0]        tile_x;
    logic [19:0]        tile_y;
    logic               last_tile;

    map_tile_range_for_view_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall),
        .latitude(latitude), .longitude(longitude),
        .tile_valid(tile_valid), .tile_stall(tile_stall),
        .tile_x(tile_x), .tile_y(tile_y), .last_tile(last_tile)
    );

    always #1 clk = ~clk;

    gps_req_t    pending_reqs[$];
    tile_t       expected_tiles[$];
    logic [31:0] merc_tab[0:MERC_DEPTH];
    logic [4:0]  zoom_cfg = 5'd15;
    logic [10:0] width_cfg = 11'd1024;
    logic [10:0] height_cfg = 11'd768;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          errors = 0;
    int          reqs_taken = 0;
    int          tiles_seen = 0;
    int          cfg_phases = 0;
    bit          req_taken = 1'b0;

    function automatic logic [63:0] sine_fix(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic [63:0] artanh_fix(input logic [63:0] s_in);
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] halvings;
        s        = (s_in > Q30_ONE - 1) ? Q30_ONE - 1 : s_in;
        sum      = 0;
        halvings = 0;
        r = ((Q30_ONE + s) << 30) / (Q30_ONE - s);
        while (r >= 2 * Q30_ONE)
        begin
            r = r >> 1;
            halvings++;
        end
        z  = ((r - Q30_ONE) << 30) / (r + Q30_ONE);
        z2 = (z * z) >> 30;
        p  = z;
        for (int j = 0; j < 12; j++)
        begin
            sum += p / 64'(2 * j + 1);
            p = (p * z2) >> 30;
        end
        return sum + ((halvings * LN2_Q30) >> 1);
    endfunction

    task automatic tile_bounds(input logic [63:0] pix, input logic [63:0] half,
                               input logic [63:0] max_idx,
                               output logic [63:0] lo, output logic [63:0] hi);
        logic [63:0] h;
        h = half << 16;
        if (pix < h)
            lo = 0;
        else
        begin
            lo = ((pix - h) >> 16) / TILE_PIXELS;
            lo = (lo >= 1) ? lo - 1 : 0;
        end
        hi = ((pix + h) >> 16) / TILE_PIXELS + 1;
        if (hi > max_idx)
            hi = max_idx;
        if (hi > lo + (MAX_TILES - 1))
            hi = lo + (MAX_TILES - 1);
    endtask

    task automatic predict_tiles(input gps_req_t r);
        logic [63:0] lat_raw;
        logic [63:0] a;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] wgt;
        logic [63:0] m;
        logic [63:0] fx;
        logic [63:0] fy;
        logic [63:0] world;
        logic [63:0] z;
        logic [63:0] max_idx;
        logic [63:0] x0;
        logic [63:0] x1;
        logic [63:0] y0;
        logic [63:0] y1;
        logic [63:0] t0;
        logic [63:0] t1;
        longint      lonv;
        bit          south;
        tile_t       t;
        z       = (zoom_cfg > MAX_ZOOM) ? MAX_ZOOM : zoom_cfg;
        max_idx = (64'd1 << z) - 1;
        world   = 64'(TILE_PIXELS) << z;
        lonv = longint'(r.lon);
        if (lonv > 1800000000)
            lonv = 1800000000;
        if (lonv < -1800000000)
            lonv = -1800000000;
        fx = (64'(lonv + 1800000000) << 32) / 64'd3600000000;
        lat_raw = {33'd0, r.lat};
        south   = lat_raw[30];
        a = south ? (64'h80000000 - lat_raw) : lat_raw;
        if (a > LAT_LIMIT)
            a = LAT_LIMIT;
        p   = ((a * MERC_DEPTH) << 16) / LAT_LIMIT;
        idx = p >> 16;
        wgt = p & 64'hFFFF;
        if (idx >= MERC_DEPTH)
            m = merc_tab[MERC_DEPTH];
        else
        begin
            t0 = merc_tab[idx];
            t1 = merc_tab[idx + 1];
            m  = t0 + ((((t1 > t0) ? t1 - t0 : 64'd0) * wgt) >> 16);
        end
        if (m > Q30_ONE)
            m = Q30_ONE;
        fy = south ? 2 * (Q30_ONE + m) : 2 * (Q30_ONE - m);
        tile_bounds((fx * world) >> 16, 64'(width_cfg >> 1), max_idx, x0, x1);
        tile_bounds((fy * world) >> 16, 64'(height_cfg >> 1), max_idx, y0, y1);
        for (logic [63:0] x = x0; x <= x1; x++)
            for (logic [63:0] y = y0; y <= y1; y++)
            begin
                t.x    = x[19:0];
                t.y    = y[19:0];
                t.last = (x == x1) && (y == y1);
                expected_tiles.insert(expected_tiles.size(), t);
            end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            predict_tiles('{lat: latitude, lon: longitude});
            reqs_taken++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                gps_req_t r;
                r = pending_reqs.pop_front();
                latitude  <= r.lat;
                longitude <= r.lon;
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // tile stall and monitor
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            tile_stall <= 1'b1;
            hold_cycles--;
        end
        else
            tile_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (tile_valid && !tile_stall)
        begin
            tiles_seen++;
            if (expected_tiles.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected tile x=%0d y=%0d last=%0b",
                         $time, tile_x, tile_y, last_tile);
            end
            else
            begin
                tile_t e;
                e = expected_tiles.pop_front();
                if (tile_x !== e.x)
                begin
                    errors++;
                    $display("%0t: tile_x expected %0d got %0d", $time, e.x, tile_x);
                end
                if (tile_y !== e.y)
                begin
                    errors++;
                    $display("%0t: tile_y expected %0d got %0d", $time, e.y, tile_y);
                end
                if (last_tile !== e.last)
                begin
                    errors++;
                    $display("%0t: last_tile expected %0b got %0b",
                             $time, e.last, last_tile);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ZOOM:   zoom_cfg = val[4:0];
            REG_WIDTH:  width_cfg = val;
            REG_HEIGHT: height_cfg = val;
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [10:0] zm, input logic [10:0] w, input logic [10:0] h);
        write_reg(REG_ZOOM, zm);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_phases++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_tiles.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic add_req(input logic signed [30:0] lat, input logic signed [31:0] lon);
        gps_req_t r;
        r.lat = lat;
        r.lon = lon;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic add_random(input int n);
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        int                 pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                lat = 31'(int'($urandom_range(1701022576)) - 850511288);
            else if (pick < 85)
                lat = 31'($urandom);
            else
                lat = 31'(($urandom_range(1) ? 850511288 : -850511288)
                          + int'($urandom_range(2000)) - 1000);
            if ($urandom_range(99) < 80)
                lon = 32'(longint'($urandom_range(3600000000)) - 1800000000);
            else
                lon = 32'($urandom);
            add_req(lat, lon);
        end
    endtask

    task automatic random_view();
        set_view(11'($urandom_range(31)), 11'($urandom_range(2047)),
                 11'($urandom_range(2047)));
    endtask

    initial
    begin
        for (int i = 0; i < MERC_DEPTH; i++)
        begin
            logic [63:0] m;
            m = (artanh_fix(sine_fix((PHI_MAX_Q30 * i) / MERC_DEPTH)) * Q30_ONE) / PI_Q30;
            merc_tab[i] = (m > Q30_ONE) ? Q30_ONE[31:0] : m[31:0];
        end
        merc_tab[MERC_DEPTH] = Q30_ONE[31:0];
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset view
        add_req(31'sd0, 32'sd0);
        add_req(31'sd850511288, 32'sd0);
        add_req(-31'sd850511288, 32'sd0);
        add_req(31'sd850511289, 32'sd1800000000);
        add_req(-31'sd850511289, -32'sd1800000000);
        add_req(31'sd900000000, 32'sd1800000001);
        add_req(-31'sd900000000, -32'sd1800000001);
        add_req(31'sh3FFFFFFF, 32'sh7FFFFFFF);
        add_req(31'sh40000000, 32'sh80000000);
        add_req(31'sd830560, 32'sd1);
        add_req(-31'sd1, -32'sd1);
        add_req(31'sd425255644, 32'sd1799999999);
        wait_drained();
        set_view(11'd0, 11'd0, 11'd0);
        add_req(31'sd0, 32'sd0);
        add_req(31'sd850511288, 32'sd1800000000);
        add_req(-31'sd850511288, -32'sd1800000000);
        wait_drained();
        set_view(11'd31, 11'd2047, 11'd2047);
        add_req(31'sd0, 32'sd0);
        add_req(31'sd850511288, 32'sd1800000000);
        add_req(-31'sd300000000, -32'sd1800000000);
        wait_drained();
        set_view(11'd20, 11'd1280, 11'd1280);
        add_req(31'sd123456789, -32'sd987654321);
        add_req(-31'sd850511288, 32'sd1800000000);
        wait_drained();

        set_view(11'd15, 11'd1024, 11'd768);
        add_random(50);
        wait_drained();

        random_view();
        send_idle_pct = 54;
        add_random(40);
        wait_drained();

        set_view(11'd1, 11'd1280, 11'd1280);
        send_idle_pct = 0;
        stall_pct = 54;
        add_random(20);
        wait_drained();

        random_view();
        send_idle_pct = 28;
        stall_pct = 28;
        add_random(40);
        wait_drained();

        // long receiver hold while requests keep coming
        set_view(11'd18, 11'd2047, 11'd2047);
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_cycles = 400;
        add_random(30);
        wait_drained();

        random_view();
        send_idle_pct = 54;
        stall_pct = 54;
        add_random(30);
        wait_drained();

        set_view(11'd5, 11'd600, 11'd333);
        send_idle_pct = 28;
        stall_pct = 28;
        add_random(30);
        wait_drained();

        $display("Covered %0d requests, %0d tiles over %0d view settings,",
                 reqs_taken, tiles_seen, cfg_phases);
        $display("with polar, antimeridian, zoom and view extremes and idle/stall mixes.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mtr_pkg.sv
design/map_tile_range_for_view_unit.sv
design/mtr_checker.sv
verif/map_tile_range_for_view_unit_tb.sv
